[design/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/vn_pkg.sv]
// Package with the field widths and constants of the vector normalize block.
`default_nettype none
package vn_pkg;
  localparam int CW_DEFAULT = 16;
  localparam int DIM_W      = 3;
  localparam int UNIT_W     = 16;
  localparam int UNIT_FRAC  = 14;
  localparam int QUO_W      = 15;
  localparam int MAG_W      = 17;
  localparam logic [DIM_W-1:0] DIM_THREE = 3'd3;
  localparam logic [DIM_W-1:0] DIM_FOUR  = 3'd4;
endpackage
`default_nettype wire

[design/vector_normalize_core.sv]
// Top level of the vector magnitude and normalization pipeline.
//
//  channel | direction | tdata                                  | tuser
//  s_*     | in        | dimension, comp_x, comp_y, comp_z, w   | -
//  m_*     | out       | magnitude, unit_x, unit_y, unit_z, w   | zero_vector
//
// One word is accepted per cycle while s_tready is high; each result passes stages A,
// B and C, the square root stages (one root bit each), the divider stages (one
// quotient bit each) and the output register.
// Reset clears the valid bits only; data registers hold whatever they last saw.
// A stall at the output freezes every stage together, so s_tready falls with it.
`default_nettype none
module vector_normalize_core import vn_pkg::*; #(
  parameter int COMPONENT_WIDTH = CW_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // dimension, comp_x, comp_y, comp_z, comp_w from bit 0 up, zero fill on top
  input  wire logic [((DIM_W+4*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // magnitude, unit_x, unit_y, unit_z, unit_w from bit 0 up, zero fill on top
  output logic [((MAG_W+4*UNIT_W+7)/8)*8-1:0] m_tdata,
  // zero_vector
  output logic [0:0] m_tuser
);
  localparam int CW    = COMPONENT_WIDTH;
  localparam int R     = CW + 1;
  localparam int SUM_W = 2 * CW + 1;
  localparam int L     = 3 + R + QUO_W;
  localparam int OTW   = ((MAG_W + 4 * UNIT_W + 7) / 8) * 8;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic [L-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[L-2:0], s_tvalid};
      m_tvalid <= vld[L-1];
    end
  end

  // Stage A: select the components in use and split into magnitude and sign.
  logic [DIM_W-1:0] dim;
  logic [3:0]       use_c;
  logic [CW-1:0]    mag_a [4];
  logic             neg_a [4];
  assign dim   = s_tdata[DIM_W-1:0];
  assign use_c = {dim >= DIM_FOUR, dim >= DIM_THREE, 2'b11};

  for (genvar i = 0; i < 4; i++) begin : g_in
    logic [CW-1:0] raw;
    logic          sgn;
    assign raw = s_tdata[DIM_W+i*CW +: CW];
    assign sgn = raw[CW-1] && use_c[i];
    always_ff @(posedge clk) begin
      if (adv) begin
        neg_a[i] <= sgn;
        mag_a[i] <= !use_c[i] ? '0 : (sgn ? (~raw + 1'b1) : raw);
      end
    end
  end

  // Stage B: squares.  Stage C: sum of squares.
  logic [2*CW-1:0] sq_b  [4];
  logic [CW-1:0]   mag_b [4];
  logic            neg_b [4];
  logic [CW-1:0]   mag_c [4];
  logic            neg_c [4];
  logic [SUM_W-1:0] sum_c;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        sq_b[i]  <= mag_a[i] * mag_a[i];
        mag_b[i] <= mag_a[i];
        neg_b[i] <= neg_a[i];
        mag_c[i] <= mag_b[i];
        neg_c[i] <= neg_b[i];
      end
      sum_c <= SUM_W'(sq_b[0]) + SUM_W'(sq_b[1]) + SUM_W'(sq_b[2]) + SUM_W'(sq_b[3]);
    end
  end

  logic [R-1:0] root;
  vn_sqrt #(.R(R)) u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand ((2*R)'(sum_c)),
    .root     (root)
  );

  // Components wait alongside the square root stages.
  logic [CW-1:0] mag_d [R][4];
  logic          neg_d [R][4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        mag_d[0][i] <= mag_c[i];
        neg_d[0][i] <= neg_c[i];
        for (int s = 1; s < R; s++) begin
          mag_d[s][i] <= mag_d[s-1][i];
          neg_d[s][i] <= neg_d[s-1][i];
        end
      end
    end
  end

  logic [QUO_W-1:0] quo   [4];
  logic             neg_q [4];
  for (genvar i = 0; i < 4; i++) begin : g_div
    vn_div #(.CW(CW), .R(R)) u_div (
      .clk     (clk),
      .en      (adv),
      .divisor (root),
      .mag     (mag_d[R-1][i]),
      .neg     (neg_d[R-1][i]),
      .quo     (quo[i]),
      .neg_out (neg_q[i])
    );
  end

  // The magnitude waits alongside the divider stages.
  logic [R-1:0] root_d [QUO_W];
  always_ff @(posedge clk) begin
    if (adv) begin
      root_d[0] <= root;
      for (int s = 1; s < QUO_W; s++) root_d[s] <= root_d[s-1];
    end
  end

  // Output register.  A zero magnitude forces zero units, as the division is void.
  logic              zero;
  logic [UNIT_W-1:0] unit [4];
  assign zero = (root_d[QUO_W-1] == '0);
  for (genvar i = 0; i < 4; i++) begin : g_unit
    logic [UNIT_W-1:0] q_ext;
    assign q_ext   = UNIT_W'(quo[i]);
    assign unit[i] = zero ? '0 : (neg_q[i] ? (~q_ext + 1'b1) : q_ext);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OTW'({unit[3], unit[2], unit[1], unit[0], MAG_W'(root_d[QUO_W-1])});
      m_tuser <= zero;
    end
  end
endmodule
`default_nettype wire

[design/vn_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module vn_sqrt import vn_pkg::*; #(
  parameter int R = CW_DEFAULT + 1
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*R-1:0] radicand,
  output logic      [R-1:0]   root
);
  localparam int RW = R + 2;
  localparam int NW = 2 * R;

  logic [RW-1:0] rem_q  [R];
  logic [R-1:0]  root_q [R];
  logic [NW-1:0] src_q  [R];

  for (genvar i = 0; i < R; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [R-1:0]  root_in;
    logic [NW-1:0] src_in;
    logic [RW+1:0] cat;
    logic [RW+1:0] trial;
    logic          ge;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign src_in  = radicand;
    end else begin : g_rest
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign src_in  = src_q[i-1];
    end
    assign cat   = {rem_in, src_in[NW-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = (cat >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= RW'(ge ? (cat - trial) : cat);
        root_q[i] <= {root_in[R-2:0], ge};
        src_q[i]  <= src_in << 2;
      end
    end
  end

  assign root = root_q[R-1];
endmodule
`default_nettype wire

[design/vn_div.sv]
// Pipelined restoring divider for one lane, one quotient bit per stage.
`default_nettype none
module vn_div import vn_pkg::*; #(
  parameter int CW = CW_DEFAULT,
  parameter int R  = CW_DEFAULT + 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [R-1:0]     divisor,
  input  wire logic [CW-1:0]    mag,
  input  wire logic             neg,
  output logic      [QUO_W-1:0] quo,
  output logic                  neg_out
);
  localparam int DDW = CW + UNIT_FRAC;
  localparam int CPW = R + UNIT_FRAC;

  logic [DDW-1:0]   rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [R-1:0]     dv_q  [QUO_W];
  logic             ng_q  [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - 1 - j;
    logic [DDW-1:0]   rem_in;
    logic [QUO_W-1:0] quo_in;
    logic [R-1:0]     dv_in;
    logic             ng_in;
    logic [CPW-1:0]   shifted;
    logic [CPW-1:0]   wide;
    logic             ge;
    if (j == 0) begin : g_first
      assign rem_in = {mag, {UNIT_FRAC{1'b0}}};
      assign quo_in = '0;
      assign dv_in  = divisor;
      assign ng_in  = neg;
    end else begin : g_rest
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign dv_in  = dv_q[j-1];
      assign ng_in  = ng_q[j-1];
    end
    assign shifted = CPW'(dv_in) << K;
    assign wide    = CPW'(rem_in);
    assign ge      = (wide >= shifted);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= DDW'(ge ? (wide - shifted) : wide);
        quo_q[j] <= {quo_in[QUO_W-2:0], ge};
        dv_q[j]  <= dv_in;
        ng_q[j]  <= ng_in;
      end
    end
  end

  assign quo     = quo_q[QUO_W-1];
  assign neg_out = ng_q[QUO_W-1];
endmodule
`default_nettype wire

[design/vn_checker.sv]
// Port-level checker for the vector normalize core, with its bind.
`default_nettype none
`include "assert_macros.svh"
module vn_checker import vn_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((MAG_W+4*UNIT_W+7)/8)*8-1:0] m_tdata,
  input wire logic [0:0] m_tuser
);
  localparam int UB = MAG_W + 4 * UNIT_W;

  logic zero_word;
  logic held;
  assign zero_word = m_tvalid && m_tuser[0];
  assign held      = m_tvalid && !m_tready;

  // A zero vector shows zero magnitude and zero units.
  `ASSERT_NOW(a_zero_mag, clk, rst, zero_word, m_tdata[MAG_W-1:0] == '0)
  `ASSERT_NOW(a_zero_units, clk, rst, zero_word, m_tdata[UB-1:MAG_W] == '0)
  // The input side moves exactly when the output side can.
  `ASSERT_NOW(a_ready, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready))
  // A stalled word stays in place.
  `ASSERT_NEXT(a_hold, clk, rst, held, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
endmodule

bind vector_normalize_core vn_checker u_vn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
